[rtl/assert_macros.svh]
// assertion macros for the tag store rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define SATL_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked out of reset
`define SATL_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/satl_pkg.sv]
// shared types and constants of the set-associative tag store
package satl_pkg;

   localparam int ADDR_W = 32;
   localparam int WAY_W = 2;
   localparam int INDEX_W = 8;

   localparam int WAYS_DEF = 4;
   localparam int SETS_DEF = 64;
   localparam int LINE_BYTES_DEF = 64;
   localparam int AGE_BITS_DEF = 8;

   typedef enum logic {
      OP_LOOKUP = 1'b0,
      OP_INSERT = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_UPDATE
   } state_type;

   typedef struct packed {
      logic clr_en;
      logic accept;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic out_free;
   } status_type;

endpackage

[rtl/satl_req_if.sv]
// request channel: operation and byte address
interface satl_req_if;
   import satl_pkg::*;

   logic valid;
   logic ready;
   logic operation;
   logic [ADDR_W-1:0] address;

   modport source (output valid, output operation, output address, input ready);
   modport sink (input valid, input operation, input address, output ready);
endinterface

[rtl/satl_rsp_if.sv]
// response channel: hit flag, way and line index
interface satl_rsp_if;
   import satl_pkg::*;

   logic valid;
   logic ready;
   logic hit;
   logic [WAY_W-1:0] way;
   logic [INDEX_W-1:0] line_index;

   modport source (output valid, output hit, output way, output line_index, input ready);
   modport sink (input valid, input hit, input way, input line_index, output ready);
endinterface

[rtl/satl_ctrl.sv]
// controller state machine: clear pass, request accept, set update
module satl_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  satl_pkg::status_type status,
   output satl_pkg::cmd_type    cmd
);
   import satl_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (status.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      cmd = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clr_en = 1'b1;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.accept = req_valid;
         end
         ST_UPDATE: begin
            cmd.commit = status.out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

[rtl/satl_dp.sv]
// datapath: tag and age/valid memories, way selection, lru update, response register
module satl_dp #(
   parameter int WAYS = satl_pkg::WAYS_DEF,
   parameter int SETS = satl_pkg::SETS_DEF,
   parameter int LINE_BYTES = satl_pkg::LINE_BYTES_DEF,
   parameter int AGE_BITS = satl_pkg::AGE_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  satl_pkg::cmd_type            cmd,
   output satl_pkg::status_type         status,
   input  logic                         req_operation,
   input  logic [satl_pkg::ADDR_W-1:0]  req_address,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_hit,
   output logic [satl_pkg::WAY_W-1:0]   rsp_way,
   output logic [satl_pkg::INDEX_W-1:0] rsp_line_index
);
   import satl_pkg::*;

   // line size and set count are powers of two
   localparam int OFF_BITS = $clog2(LINE_BYTES);
   localparam int SET_FIELD = $clog2(SETS);
   localparam int SET_BITS = (SETS > 1) ? SET_FIELD : 1;
   localparam int WAY_BITS = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int TAG_LEN = ADDR_W - OFF_BITS - SET_FIELD;
   localparam int IDX_FULL = SET_BITS + 6;

   typedef struct packed {
      logic [WAYS-1:0]               valid;
      logic [WAYS-1:0][AGE_BITS-1:0] age;
   } meta_row_type;

   typedef logic [WAYS-1:0][TAG_LEN-1:0] tag_row_type;

   function automatic logic [AGE_BITS-1:0] age_inc(input logic [AGE_BITS-1:0] a);
      return (a == '1) ? a : a + 1'b1;
   endfunction

   meta_row_type meta_mem [SETS];
   tag_row_type  tag_mem [SETS];

   meta_row_type meta_rd_ff;
   tag_row_type  tag_rd_ff;
   op_type                op_ff;
   logic [SET_BITS-1:0]   set_ff;
   logic [TAG_LEN-1:0]    tag_ff;
   logic [SET_BITS-1:0]   clr_idx_ff;
   logic [SET_BITS-1:0]   clr_idx_in;

   logic                  rsp_valid_ff;
   logic                  rsp_hit_ff;
   logic [WAY_W-1:0]      rsp_way_ff;
   logic [INDEX_W-1:0]    rsp_line_index_ff;

   logic [ADDR_W-1:0]     line_addr;
   logic [SET_BITS-1:0]   set_addr;
   logic [TAG_LEN-1:0]    tag_addr;

   logic [WAYS-1:0]       match;
   logic                  hit_found;
   logic [WAY_BITS-1:0]   hit_way;
   logic [AGE_BITS-1:0]   hit_age;
   logic                  inv_found;
   logic [WAY_BITS-1:0]   inv_way;
   logic [WAY_BITS-1:0]   old_way;
   logic [AGE_BITS-1:0]   old_age;
   logic [WAY_BITS-1:0]   ins_way;
   logic [WAY_BITS-1:0]   pick;
   meta_row_type          meta_new;
   tag_row_type           tag_new;
   logic                  meta_we;
   logic [SET_BITS-1:0]   meta_waddr;
   meta_row_type          meta_wdata;
   logic                  tag_we;
   logic                  rsp_hit_in;
   logic [WAY_W-1:0]      rsp_way_in;
   logic [IDX_FULL-1:0]   idx_full;
   logic [INDEX_W-1:0]    rsp_line_index_in;

   // address split
   assign line_addr = req_address >> OFF_BITS;
   assign set_addr = SET_BITS'(line_addr % SETS);
   assign tag_addr = TAG_LEN'(line_addr >> SET_FIELD);

   // request capture and registered set read
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff <= op_type'(req_operation);
         set_ff <= set_addr;
         tag_ff <= tag_addr;
         meta_rd_ff <= meta_mem[set_addr];
         tag_rd_ff <= tag_mem[set_addr];
      end
   end

   // clear pass counter
   assign clr_idx_in = clr_idx_ff + 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_idx_ff <= '0;
      end else if (cmd.clr_en) begin
         clr_idx_ff <= clr_idx_in;
      end
   end

   assign status.clr_last = (clr_idx_ff == SET_BITS'(SETS - 1));
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   // way selection on the captured set
   always_comb begin
      hit_found = 1'b0;
      hit_way = '0;
      inv_found = 1'b0;
      inv_way = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         match[w] = meta_rd_ff.valid[w] && (tag_rd_ff[w] == tag_ff);
         if (match[w]) begin
            hit_found = 1'b1;
            hit_way = WAY_BITS'(w);
         end
         if (!meta_rd_ff.valid[w]) begin
            inv_found = 1'b1;
            inv_way = WAY_BITS'(w);
         end
      end
   end

   // oldest way, ties to the highest
   always_comb begin
      old_way = '0;
      old_age = '0;
      for (int w = 0; w < WAYS; w++) begin
         if (meta_rd_ff.age[w] >= old_age) begin
            old_age = meta_rd_ff.age[w];
            old_way = WAY_BITS'(w);
         end
      end
   end

   assign ins_way = inv_found ? inv_way : old_way;
   assign hit_age = meta_rd_ff.age[hit_way];
   assign pick = (op_ff == OP_INSERT) ? ins_way : hit_way;

   always_comb begin
      meta_new = meta_rd_ff;
      tag_new = tag_rd_ff;
      if (op_ff == OP_INSERT) begin
         for (int w = 0; w < WAYS; w++) begin
            meta_new.age[w] = age_inc(meta_rd_ff.age[w]);
         end
         meta_new.age[ins_way] = '0;
         meta_new.valid[ins_way] = 1'b1;
         tag_new[ins_way] = tag_ff;
      end else begin
         for (int w = 0; w < WAYS; w++) begin
            if (meta_rd_ff.age[w] < hit_age) meta_new.age[w] = age_inc(meta_rd_ff.age[w]);
         end
         meta_new.age[hit_way] = '0;
      end
   end

   // write port shared by the clear pass and the update
   assign meta_we = cmd.clr_en || (cmd.commit && ((op_ff == OP_INSERT) || hit_found));
   assign meta_waddr = cmd.clr_en ? clr_idx_ff : set_ff;
   assign meta_wdata = cmd.clr_en ? meta_row_type'('0) : meta_new;
   assign tag_we = cmd.commit && (op_ff == OP_INSERT);

   always_ff @(posedge clock) begin
      if (meta_we) begin
         meta_mem[meta_waddr] <= meta_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (tag_we) begin
         tag_mem[set_ff] <= tag_new;
      end
   end

   // response fields, all zero on a lookup miss
   assign idx_full = IDX_FULL'(set_ff) * IDX_FULL'(WAYS) + IDX_FULL'(pick);
   always_comb begin
      rsp_hit_in = 1'b0;
      rsp_way_in = '0;
      rsp_line_index_in = '0;
      if ((op_ff == OP_INSERT) || hit_found) begin
         rsp_hit_in = (op_ff == OP_LOOKUP);
         rsp_way_in = WAY_W'(pick);
         rsp_line_index_in = INDEX_W'(idx_full);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_hit_ff <= rsp_hit_in;
         rsp_way_ff <= rsp_way_in;
         rsp_line_index_ff <= rsp_line_index_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_hit = rsp_hit_ff;
   assign rsp_way = rsp_way_ff;
   assign rsp_line_index = rsp_line_index_ff;

endmodule

[rtl/set_assoc_tag_store_lru_top.sv]
// top level of the set-associative tag store with age-counter lru
//
// req_chan carries a request: operation (lookup and touch, or insert) and
// a byte address, split into line offset, set index and tag.
// rsp_chan returns one response per request: hit flag, way and line index
// (set times ways plus way); a lookup miss returns all zero.
// A request is accepted when valid and ready are both high. The response is
// valid once the set row, read into a register, has been written back;
// ready is high again in the idle state after that, so a new request is
// taken only once the last one is done.
// After reset a clearing pass zeroes the valid bits and ages, one set per
// cycle, through all sets; req_chan.ready stays low meanwhile.
// The response sits in an output register; a new request is taken while it
// waits, and if the receiver still stalls when that request is done, the
// block holds it and keeps ready low until the register frees up.
// Line size and set count are powers of two.
module set_assoc_tag_store_lru_top #(
   parameter int WAYS = satl_pkg::WAYS_DEF,
   parameter int SETS = satl_pkg::SETS_DEF,
   parameter int LINE_BYTES = satl_pkg::LINE_BYTES_DEF,
   parameter int AGE_BITS = satl_pkg::AGE_BITS_DEF
) (
   input logic        clock,
   input logic        reset,
   satl_req_if.sink   req_chan,
   satl_rsp_if.source rsp_chan
);
   import satl_pkg::*;

   `include "assert_macros.svh"

   cmd_type    cmd;
   status_type status;
   logic       req_ready;

   satl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   satl_dp #(
      .WAYS       (WAYS),
      .SETS       (SETS),
      .LINE_BYTES (LINE_BYTES),
      .AGE_BITS   (AGE_BITS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_operation  (req_chan.operation),
      .req_address    (req_chan.address),
      .rsp_valid      (rsp_chan.valid),
      .rsp_ready      (rsp_chan.ready),
      .rsp_hit        (rsp_chan.hit),
      .rsp_way        (rsp_chan.way),
      .rsp_line_index (rsp_chan.line_index)
   );

   assign req_chan.ready = req_ready;

   `SATL_ASSERT_IMPL(a_no_accept_in_clear, cmd.clr_en, !req_chan.ready, "request ready during clear")
   `SATL_ASSERT_IMPL(a_commit_out_free, cmd.commit, !(rsp_chan.valid && !rsp_chan.ready), "response overwritten")
   `SATL_ASSERT_NEXT(a_busy_after_accept, req_chan.valid && req_chan.ready, !req_chan.ready, "request taken while busy")
   `SATL_ASSERT_NEXT(a_rsp_after_commit, cmd.commit, rsp_chan.valid, "response missing after update")

endmodule

[tb/sv/satl_tb_pkg.sv]
// scoreboard for the tag store: lru state predictor and response checker
`timescale 1ns / 1ps
package satl_tb_pkg;
   import satl_pkg::*;

   localparam int LINE_BITS = $clog2(LINE_BYTES_DEF);
   localparam int SET_BITS = $clog2(SETS_DEF);
   localparam int TAG_W = ADDR_W - LINE_BITS - SET_BITS;
   localparam int ENTRY_CNT = SETS_DEF * WAYS_DEF;
   localparam logic [AGE_BITS_DEF-1:0] AGE_MAX = '1;

   typedef struct packed {
      logic hit;
      logic [WAY_W-1:0] way;
      logic [INDEX_W-1:0] line_index;
   } lru_rsp_type;

   class tag_lru_scoreboard;
      logic [TAG_W-1:0] line_tag[ENTRY_CNT];
      bit line_valid[ENTRY_CNT];
      logic [AGE_BITS_DEF-1:0] line_age[ENTRY_CNT];
      lru_rsp_type expected_rsps[$];
      int mismatches;
      int checked;
      int lookups;
      int lookup_hits;
      int inserts;

      function new();
         for (int i = 0; i < ENTRY_CNT; i++) begin
            line_valid[i] = 1'b0;
            line_age[i] = '0;
            line_tag[i] = '0;
         end
         mismatches = 0;
         checked = 0;
         lookups = 0;
         lookup_hits = 0;
         inserts = 0;
      endfunction

      function logic [AGE_BITS_DEF-1:0] aged(logic [AGE_BITS_DEF-1:0] a);
         return (a == AGE_MAX) ? a : a + 1'b1;
      endfunction

      // applies one request to the mirrored set state and returns its response
      function lru_rsp_type predict_access(op_type op, logic [ADDR_W-1:0] addr);
         int base;
         int pick;
         int idx;
         bit matched;
         bit found_free;
         logic [TAG_W-1:0] tag;
         logic [AGE_BITS_DEF-1:0] hit_age;
         logic [AGE_BITS_DEF-1:0] oldest;
         lru_rsp_type rsp;
         base = int'(addr[LINE_BITS +: SET_BITS]) * WAYS_DEF;
         tag = addr[ADDR_W-1 -: TAG_W];
         pick = 0;
         matched = 1'b0;
         found_free = 1'b0;
         oldest = '0;
         rsp = '0;
         if (op == OP_LOOKUP) begin
            lookups++;
            // lowest matching way wins when a tag is present twice
            for (int w = 0; w < WAYS_DEF; w++) begin
               if (!matched && line_valid[base + w] && line_tag[base + w] == tag) begin
                  pick = w;
                  matched = 1'b1;
               end
            end
            if (matched) begin
               lookup_hits++;
               hit_age = line_age[base + pick];
               for (int w = 0; w < WAYS_DEF; w++) begin
                  if (line_age[base + w] < hit_age)
                     line_age[base + w] = aged(line_age[base + w]);
               end
               line_age[base + pick] = '0;
               idx = base + pick;
               rsp.hit = 1'b1;
               rsp.way = pick[WAY_W-1:0];
               rsp.line_index = idx[INDEX_W-1:0];
            end
         end else begin
            inserts++;
            // first invalid way, else oldest with ties to the higher way
            for (int w = 0; w < WAYS_DEF; w++) begin
               if (!found_free) begin
                  if (!line_valid[base + w]) begin
                     pick = w;
                     found_free = 1'b1;
                  end else if (line_age[base + w] >= oldest) begin
                     oldest = line_age[base + w];
                     pick = w;
                  end
               end
            end
            for (int w = 0; w < WAYS_DEF; w++)
               line_age[base + w] = aged(line_age[base + w]);
            line_age[base + pick] = '0;
            line_valid[base + pick] = 1'b1;
            line_tag[base + pick] = tag;
            idx = base + pick;
            rsp.way = pick[WAY_W-1:0];
            rsp.line_index = idx[INDEX_W-1:0];
         end
         return rsp;
      endfunction

      function void note_request(op_type op, logic [ADDR_W-1:0] addr);
         expected_rsps.push_back(predict_access(op, addr));
      endfunction

      function void check_response(lru_rsp_type got);
         lru_rsp_type exp;
         checked++;
         if (expected_rsps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("response with no request pending: hit=%0b way=%0d index=%0d",
                        got.hit, got.way, got.line_index);
            return;
         end
         exp = expected_rsps.pop_front();
         if (got.hit !== exp.hit || got.way !== exp.way || got.line_index !== exp.line_index)
         begin
            mismatches++;
            if (mismatches <= 10)
               $display("response %0d mismatch: hit %0b/%0b way %0d/%0d index %0d/%0d (exp/act)",
                        checked, exp.hit, got.hit, exp.way, got.way,
                        exp.line_index, got.line_index);
         end
      endfunction

      function int outstanding();
         return expected_rsps.size();
      endfunction
   endclass

endpackage

[tb/sv/tb_set_assoc_tag_store_lru_top.sv]
// testbench top: random and directed lookups and inserts against the lru tag store
`timescale 1ns / 1ps
module tb_set_assoc_tag_store_lru_top;
   import satl_pkg::*;
   import satl_tb_pkg::*;

   localparam int RANDOM_REQUESTS = 1900;
   localparam int CYCLE_LIMIT = 400000;

   logic clock = 1'b0;
   logic reset;
   int cycle_count = 0;
   bit req_steady = 1'b0;
   bit rsp_steady = 1'b0;
   logic [TAG_W-1:0] hot_tags[8];
   int hot_sets[4];
   tag_lru_scoreboard sb;

   satl_req_if req_chan();
   satl_rsp_if rsp_chan();

   set_assoc_tag_store_lru_top uut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses pending",
                  cycle_count, sb.outstanding());
         $display("== FAIL ==");
         $finish;
      end
   end

   function automatic int draw_gap(bit steady);
      return steady ? 0 : $urandom_range(0, 15);
   endfunction

   function automatic logic [ADDR_W-1:0] line_addr(logic [TAG_W-1:0] tag, int set_idx,
                                                    int offset);
      logic [SET_BITS-1:0] s;
      logic [LINE_BITS-1:0] o;
      s = set_idx[SET_BITS-1:0];
      o = offset[LINE_BITS-1:0];
      return {tag, s, o};
   endfunction

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_request(op_type op, logic [ADDR_W-1:0] addr);
      int gap;
      gap = draw_gap(req_steady);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.operation <= op;
      req_chan.address <= addr;
      do
         @(posedge clock);
      while (req_chan.ready !== 1'b1);
      sb.note_request(op, addr);
      @(negedge clock);
   endtask

   task automatic refresh_hot_lines();
      for (int i = 0; i < 8; i++)
         hot_tags[i] = TAG_W'($urandom);
      for (int i = 0; i < 4; i++)
         hot_sets[i] = $urandom_range(0, SETS_DEF - 1);
   endtask

   // response side: random back-pressure, check at every accepted response
   initial begin
      int stall;
      int rsp_count;
      lru_rsp_type got;
      stall = 0;
      rsp_count = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
            got.hit = rsp_chan.hit;
            got.way = rsp_chan.way;
            got.line_index = rsp_chan.line_index;
            sb.check_response(got);
            rsp_count++;
            if (rsp_count % 150 == 0)
               rsp_steady = ($urandom_range(0, 3) == 0);
            stall = draw_gap(rsp_steady);
         end
         @(negedge clock);
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            stall--;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   initial begin
      op_type op;
      logic [TAG_W-1:0] tag;
      int set_idx;
      sb = new();
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.operation = 1'b0;
      req_chan.address = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty set miss, then fill and hit at both ends of the address range
      send_request(OP_LOOKUP, '0);
      send_request(OP_INSERT, '0);
      send_request(OP_LOOKUP, line_addr('0, 0, LINE_BYTES_DEF - 1));
      send_request(OP_INSERT, '1);
      send_request(OP_LOOKUP, line_addr('1, SETS_DEF - 1, 0));
      // fill one set, touch a middle way, miss in a full set, evict the oldest
      for (int t = 1; t <= 4; t++)
         send_request(OP_INSERT, line_addr(TAG_W'(t), 5, t));
      send_request(OP_LOOKUP, line_addr(TAG_W'(2), 5, 0));
      send_request(OP_LOOKUP, line_addr(TAG_W'(7), 5, 0));
      send_request(OP_INSERT, line_addr(TAG_W'(5), 5, 9));
      send_request(OP_LOOKUP, line_addr(TAG_W'(1), 5, 0));
      send_request(OP_LOOKUP, line_addr(TAG_W'(4), 5, 63));
      send_request(OP_INSERT, line_addr(TAG_W'(6), 5, 0));
      send_request(OP_LOOKUP, line_addr(TAG_W'(3), 5, 0));
      // same line inserted twice: later lookups hit the lower way
      send_request(OP_INSERT, line_addr(TAG_W'(20'hABCDE), 9, 0));
      send_request(OP_INSERT, line_addr(TAG_W'(20'hABCDE), 9, 17));
      send_request(OP_LOOKUP, line_addr(TAG_W'(20'hABCDE), 9, 42));
      send_request(OP_INSERT, line_addr(TAG_W'(20'h54321), 9, 0));
      send_request(OP_INSERT, line_addr(TAG_W'(20'h54321), 9, 0));
      send_request(OP_INSERT, line_addr(TAG_W'(20'h11111), 9, 0));
      send_request(OP_LOOKUP, line_addr(TAG_W'(20'h54321), 9, 0));

      // random traffic concentrated on a few sets and tags to drive hits and evictions
      refresh_hot_lines();
      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         if (n % 300 == 299)
            refresh_hot_lines();
         if (n % 150 == 0)
            req_steady = ($urandom_range(0, 3) == 0);
         op = ($urandom_range(0, 9) < 4) ? OP_INSERT : OP_LOOKUP;
         if ($urandom_range(0, 9) < 7)
            set_idx = hot_sets[$urandom_range(0, 3)];
         else
            set_idx = $urandom_range(0, SETS_DEF - 1);
         if ($urandom_range(0, 19) < 17)
            tag = hot_tags[$urandom_range(0, 7)];
         else
            tag = TAG_W'($urandom);
         send_request(op, line_addr(tag, set_idx, $urandom_range(0, LINE_BYTES_DEF - 1)));
      end
      req_chan.valid <= 1'b0;

      while (sb.outstanding() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);

      $display("%0d responses checked: %0d lookups with %0d hits, %0d inserts",
               sb.checked, sb.lookups, sb.lookup_hits, sb.inserts);
      $display("%0d mismatches in %0d cycles", sb.mismatches, cycle_count);
      if (sb.mismatches == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

[set_assoc_tag_store_lru_top.f]
+incdir+rtl
rtl/satl_pkg.sv
rtl/satl_req_if.sv
rtl/satl_rsp_if.sv
rtl/satl_ctrl.sv
rtl/satl_dp.sv
rtl/set_assoc_tag_store_lru_top.sv
tb/sv/satl_tb_pkg.sv
tb/sv/tb_set_assoc_tag_store_lru_top.sv
